// ===== rtl/frame_time_quality_governor_defines.svh =====
// Assertion macros for the frame time quality governor checker.
// Depends on nothing; expects aclk and aresetn in the scope of each use.
`ifndef FRAME_TIME_QUALITY_GOVERNOR_DEFINES_SVH
`define FRAME_TIME_QUALITY_GOVERNOR_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FTQG_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("ftqg check failed");

// Consequent must hold in the cycle after the antecedent.
`define FTQG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("ftqg check failed");

`endif

// ===== rtl/ftqg_pkg.sv =====
// Shared constants, types and codes for the frame time quality governor.
// Used by ftqg_div and frame_time_quality_governor.
package ftqg_pkg;

    localparam int WINDOW_DEPTH = 64;
    localparam int WIN_AW       = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W        = 16 + WIN_AW;

    localparam int DIV_W  = 16;
    localparam int DIV_CW = 5;
    localparam logic [DIV_CW-1:0] AVG_ITERS = 5'd16;
    localparam logic [DIV_CW-1:0] HLT_ITERS = 5'd9;

    localparam int MUL_W  = 10;
    localparam int PROD_W = 26;
    localparam logic [3:0] MUL_STEPS = 4'd10;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 48;

    localparam logic [2:0] LEVEL_MAX = 3'd4;
    localparam logic [2:0] LEVEL_MIN = 3'd0;

    localparam logic ACTION_TICK  = 1'b0;
    localparam logic ACTION_FORCE = 1'b1;

    localparam logic [2:0] CFG_AUTO_ENABLE = 3'd0;
    localparam logic [2:0] CFG_TARGET      = 3'd1;
    localparam logic [2:0] CFG_SENSITIVITY = 3'd2;
    localparam logic [2:0] CFG_CRITICAL    = 3'd3;
    localparam logic [2:0] CFG_BAD         = 3'd4;
    localparam logic [2:0] CFG_GOOD        = 3'd5;
    localparam logic [2:0] CFG_RUN_LIMIT   = 3'd6;
    localparam logic [2:0] CFG_SETTLE      = 3'd7;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PUSH,
        ST_AVG_GO,
        ST_AVG_WAIT,
        ST_HLT_GO,
        ST_HLT_WAIT,
        ST_DECIDE
    } ftqg_state_t;

    typedef struct packed {
        logic              start;
        logic [DIV_CW-1:0] iters;
    } div_req_t;

endpackage

// ===== rtl/frame_time_quality_governor.sv =====
// Frame time quality governor: one item in, one result item out.
// From acceptance to m_tvalid, the time is set by the serial divider: 16 steps for the window
// average (skipped while the window is empty), then 9 for health beside a 10-step multiply.
// One item at a time; the next is accepted the cycle after the result registers.
// aresetn is synchronous, active low; it restores defaults and level 4.
// The history memory has no reset; only entries already written are used.
module frame_time_quality_governor
    import ftqg_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // frame_time_us[15:0], delta_time_us[31:16], forced_level[34:32], zero fill
    input  logic [S_TDATA_W-1:0] s_tdata,
    // action
    input  logic                 s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // quality_level[2:0], level_changed[3], critical_seen[4], health_q8[13:5],
    // stable_flag[14], average_time_us[30:15], bad_run[38:31], good_run[47:39]
    output logic [M_TDATA_W-1:0] m_tdata,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [2:0]           cfg_index,
    input  logic [23:0]          cfg_data
);

    ftqg_state_t state_reg, state_next;

    logic        auto_en_reg;
    logic [15:0] target_reg;
    logic [9:0]  sens_reg;
    logic [9:0]  crit_reg;
    logic [9:0]  bad_reg;
    logic [9:0]  good_reg;
    logic [7:0]  limit_reg;
    logic [23:0] settle_reg;

    logic        action_reg;
    logic [15:0] ft_reg;
    logic [15:0] dt_reg;
    logic [2:0]  forced_reg;

    logic [15:0]      ring [WINDOW_DEPTH];
    logic [15:0]      rd_data_reg;
    logic [SUM_W-1:0] sum_reg;
    logic [CNT_W-1:0] count_reg;
    logic [WIN_AW-1:0] head_reg;

    logic [2:0]  level_reg, level_next;
    logic [7:0]  bad_cnt_reg, bad_cnt_next;
    logic [8:0]  good_cnt_reg, good_cnt_next;
    logic [31:0] timer_reg, timer_next;

    logic [15:0] avg_reg;
    logic [8:0]  health_reg;
    logic        hdone_reg;

    logic [MUL_W-1:0]  sens_sh_reg, crit_sh_reg, bad_sh_reg, good_sh_reg;
    logic [PROD_W-1:0] prod_avg_reg, prod_crit_reg, prod_bad_reg, prod_good_reg;
    logic [3:0]        mcnt_reg;

    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    div_req_t         div_req;
    logic [DIV_W-1:0] div_rem_init;
    logic [DIV_W-1:0] div_dvd;
    logic [DIV_W-1:0] div_dsr;
    logic             div_done;
    logic [DIV_W-1:0] div_quot;

    logic [15:0] tgt_eff;
    logic        run;
    logic        full;
    logic        hlt_sat;
    logic        commit;
    logic        crit_hit, bad_hit, good_hit;
    logic        crit_next;
    logic [2:0]  want;
    logic [7:0]  bad_inc;
    logic [8:0]  good_inc;
    logic [31:0] tmr_base;
    logic [32:0] tmr_sum;
    logic [8:0]  hlt_r;
    logic        stable;

    assign tgt_eff   = (target_reg == 16'd0) ? 16'd1 : target_reg;
    assign run       = (action_reg == ACTION_TICK) && auto_en_reg;
    assign full      = (count_reg == CNT_W'(WINDOW_DEPTH));
    assign hlt_sat   = ({1'b0, avg_reg} >= {tgt_eff, 1'b0});
    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            auto_en_reg <= 1'b1;
            target_reg  <= 16'd16667;
            sens_reg    <= 10'd256;
            crit_reg    <= 10'd384;
            bad_reg     <= 10'd282;
            good_reg    <= 10'd230;
            limit_reg   <= 8'd5;
            settle_reg  <= 24'd1000000;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_AUTO_ENABLE: auto_en_reg <= cfg_data[0];
                CFG_TARGET:      target_reg  <= cfg_data[15:0];
                CFG_SENSITIVITY: sens_reg    <= cfg_data[9:0];
                CFG_CRITICAL:    crit_reg    <= cfg_data[9:0];
                CFG_BAD:         bad_reg     <= cfg_data[9:0];
                CFG_GOOD:        good_reg    <= cfg_data[9:0];
                CFG_RUN_LIMIT:   limit_reg   <= cfg_data[7:0];
                CFG_SETTLE:      settle_reg  <= cfg_data[23:0];
                default: ;
            endcase
        end
    end

    // Capture the accepted item
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            action_reg <= s_tuser;
            ft_reg     <= s_tdata[15:0];
            dt_reg     <= s_tdata[31:16];
            forced_reg <= s_tdata[34:32];
        end
    end

    // History window memory
    always_ff @(posedge aclk) begin
        if ((state_reg == ST_PUSH) && run) begin
            ring[head_reg] <= ft_reg;
        end
        rd_data_reg <= ring[head_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg   <= '0;
            count_reg <= '0;
            head_reg  <= '0;
        end else if ((state_reg == ST_PUSH) && run) begin
            count_reg <= full ? count_reg : count_reg + 1'b1;
            sum_reg   <= sum_reg - (full ? SUM_W'(rd_data_reg) : '0) + SUM_W'(ft_reg);
            head_reg  <= (head_reg == WIN_AW'(WINDOW_DEPTH - 1)) ? '0 : head_reg + 1'b1;
        end
    end

    ftqg_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (div_req),
        .rem_init (div_rem_init),
        .dvd_bits (div_dvd),
        .divisor  (div_dsr),
        .done     (div_done),
        .quot     (div_quot)
    );

    always_comb begin
        div_req.start = 1'b0;
        div_req.iters = AVG_ITERS;
        div_rem_init  = DIV_W'(sum_reg[SUM_W-1:16]);
        div_dvd       = sum_reg[15:0];
        div_dsr       = DIV_W'(count_reg);
        if (state_reg == ST_HLT_GO) begin
            div_req.start = !hlt_sat;
            div_req.iters = HLT_ITERS;
            div_rem_init  = {1'b0, avg_reg[15:1]};
            div_dvd       = {avg_reg[0], 15'd0};
            div_dsr       = tgt_eff;
        end else if (state_reg == ST_AVG_GO) begin
            div_req.start = (count_reg != '0);
        end
    end

    assign hlt_r = div_quot[8:0];

    // Average, health and threshold products
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hdone_reg <= 1'b0;
            mcnt_reg  <= '0;
        end else begin
            case (state_reg)
                ST_AVG_GO: begin
                    if (count_reg == '0) begin
                        avg_reg <= '0;
                    end
                end
                ST_AVG_WAIT: begin
                    if (div_done) begin
                        avg_reg <= div_quot;
                    end
                end
                ST_HLT_GO: begin
                    hdone_reg     <= hlt_sat;
                    health_reg    <= '0;
                    mcnt_reg      <= MUL_STEPS;
                    sens_sh_reg   <= sens_reg;
                    crit_sh_reg   <= crit_reg;
                    bad_sh_reg    <= bad_reg;
                    good_sh_reg   <= good_reg;
                    prod_avg_reg  <= '0;
                    prod_crit_reg <= '0;
                    prod_bad_reg  <= '0;
                    prod_good_reg <= '0;
                end
                ST_HLT_WAIT: begin
                    if (div_done) begin
                        hdone_reg  <= 1'b1;
                        health_reg <= (hlt_r <= 9'd256) ? 9'd256 :
                                      9'(10'd512 - {1'b0, hlt_r});
                    end
                    if (mcnt_reg != '0) begin
                        mcnt_reg      <= mcnt_reg - 1'b1;
                        sens_sh_reg   <= {sens_sh_reg[MUL_W-2:0], 1'b0};
                        crit_sh_reg   <= {crit_sh_reg[MUL_W-2:0], 1'b0};
                        bad_sh_reg    <= {bad_sh_reg[MUL_W-2:0], 1'b0};
                        good_sh_reg   <= {good_sh_reg[MUL_W-2:0], 1'b0};
                        prod_avg_reg  <= (prod_avg_reg << 1) +
                                         (sens_sh_reg[MUL_W-1] ? PROD_W'(avg_reg) : '0);
                        prod_crit_reg <= (prod_crit_reg << 1) +
                                         (crit_sh_reg[MUL_W-1] ? PROD_W'(tgt_eff) : '0);
                        prod_bad_reg  <= (prod_bad_reg << 1) +
                                         (bad_sh_reg[MUL_W-1] ? PROD_W'(tgt_eff) : '0);
                        prod_good_reg <= (prod_good_reg << 1) +
                                         (good_sh_reg[MUL_W-1] ? PROD_W'(tgt_eff) : '0);
                    end
                end
                default: ;
            endcase
        end
    end

    // Level decision
    assign crit_hit = (prod_avg_reg >= prod_crit_reg);
    assign bad_hit  = (prod_avg_reg >= prod_bad_reg);
    assign good_hit = (prod_avg_reg <= prod_good_reg);
    assign bad_inc  = (bad_cnt_reg == 8'hFF) ? bad_cnt_reg : bad_cnt_reg + 1'b1;
    assign good_inc = (good_cnt_reg == 9'h1FF) ? good_cnt_reg : good_cnt_reg + 1'b1;

    always_comb begin
        level_next    = level_reg;
        bad_cnt_next  = bad_cnt_reg;
        good_cnt_next = good_cnt_reg;
        timer_next    = timer_reg;
        crit_next     = 1'b0;
        want          = level_reg;
        tmr_base      = timer_reg;
        tmr_sum       = '0;
        if (action_reg == ACTION_FORCE) begin
            if (forced_reg <= LEVEL_MAX) begin
                level_next    = forced_reg;
                bad_cnt_next  = '0;
                good_cnt_next = '0;
                timer_next    = '0;
            end
        end else if (auto_en_reg) begin
            if (crit_hit) begin
                crit_next = 1'b1;
                want      = LEVEL_MIN;
            end else if (bad_hit) begin
                bad_cnt_next  = bad_inc;
                good_cnt_next = '0;
                if ((bad_inc >= limit_reg) && (timer_reg >= {8'd0, settle_reg})) begin
                    want = (level_reg == LEVEL_MIN) ? LEVEL_MIN : level_reg - 1'b1;
                end
            end else if (good_hit) begin
                good_cnt_next = good_inc;
                bad_cnt_next  = '0;
                if ((good_inc >= {limit_reg, 1'b0}) &&
                    (timer_reg >= {7'd0, settle_reg, 1'b0})) begin
                    want = (level_reg == LEVEL_MAX) ? LEVEL_MAX : level_reg + 1'b1;
                end
            end else begin
                bad_cnt_next  = '0;
                good_cnt_next = '0;
            end
            if (want != level_reg) begin
                level_next    = want;
                bad_cnt_next  = '0;
                good_cnt_next = '0;
                tmr_base      = '0;
            end
            tmr_sum    = {1'b0, tmr_base} + 33'(dt_reg);
            timer_next = tmr_sum[32] ? 32'hFFFF_FFFF : tmr_sum[31:0];
        end
    end

    assign stable = (bad_cnt_next == 8'd0) && (good_cnt_next < {1'b0, limit_reg});

    // Sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        commit     = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH: begin
                state_next = ST_AVG_GO;
            end
            ST_AVG_GO: begin
                state_next = (count_reg == '0) ? ST_HLT_GO : ST_AVG_WAIT;
            end
            ST_AVG_WAIT: begin
                if (div_done) begin
                    state_next = ST_HLT_GO;
                end
            end
            ST_HLT_GO: begin
                state_next = ST_HLT_WAIT;
            end
            ST_HLT_WAIT: begin
                if ((mcnt_reg == '0) && hdone_reg) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (!m_tvalid_reg || m_tready) begin
                    commit     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Governor state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_reg    <= LEVEL_MAX;
            bad_cnt_reg  <= '0;
            good_cnt_reg <= '0;
            timer_reg    <= '0;
        end else if (commit) begin
            level_reg    <= level_next;
            bad_cnt_reg  <= bad_cnt_next;
            good_cnt_reg <= good_cnt_next;
            timer_reg    <= timer_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (commit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (commit) begin
            m_tdata_reg <= {good_cnt_next, bad_cnt_next, avg_reg, stable, health_reg,
                            crit_next, (level_next != level_reg), level_next};
        end
    end

endmodule

// ===== rtl/ftqg_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on ftqg_pkg; shared by the average and health computations.
module ftqg_div
    import ftqg_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  div_req_t         req,
    input  logic [DIV_W-1:0] rem_init,
    input  logic [DIV_W-1:0] dvd_bits,
    input  logic [DIV_W-1:0] divisor,
    output logic             done,
    output logic [DIV_W-1:0] quot
);

    logic [DIV_W-1:0]  rem_reg;
    logic [DIV_W-1:0]  dvd_reg;
    logic [DIV_W-1:0]  dsr_reg;
    logic [DIV_W-1:0]  quot_reg;
    logic [DIV_CW-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [DIV_W+1:0]  diff;

    assign diff = {1'b0, rem_reg, dvd_reg[DIV_W-1]} - {2'b00, dsr_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.iters;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            rem_reg  <= rem_init;
            dvd_reg  <= dvd_bits;
            dsr_reg  <= divisor;
            quot_reg <= '0;
        end else if (busy_reg) begin
            dvd_reg <= {dvd_reg[DIV_W-2:0], 1'b0};
            if (!diff[DIV_W+1]) begin
                rem_reg  <= diff[DIV_W-1:0];
                quot_reg <= {quot_reg[DIV_W-2:0], 1'b1};
            end else begin
                rem_reg  <= {rem_reg[DIV_W-2:0], dvd_reg[DIV_W-1]};
                quot_reg <= {quot_reg[DIV_W-2:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

// ===== rtl/ftqg_chk.sv =====
// Port-level checks for the frame time quality governor, bound to the top level.
// Depends on frame_time_quality_governor_defines.svh for the assertion macros.
`include "frame_time_quality_governor_defines.svh"

module ftqg_chk (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata
);

    `FTQG_ASSERT_NOW(a_level_range, m_tvalid, m_tdata[2:0] <= 3'd4)
    `FTQG_ASSERT_NOW(a_health_range, m_tvalid, m_tdata[13:5] <= 9'd256)
    `FTQG_ASSERT_NOW(a_runs_exclusive, m_tvalid, m_tdata[38:31] == 8'd0 || m_tdata[47:39] == 9'd0)
    `FTQG_ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready)
    `FTQG_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

bind frame_time_quality_governor ftqg_chk u_ftqg_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== test/frame_time_quality_governor_tb.sv =====
// Self-checking testbench for frame_time_quality_governor: stream driver, result monitor
// and an in-bench model of the level governor, window average and health score.
// Depends on ftqg_pkg and the frame_time_quality_governor RTL.
module frame_time_quality_governor_tb;
    import ftqg_pkg::*;

    typedef struct packed {
        logic        action;
        logic [15:0] frame_us;
        logic [15:0] delta_us;
        logic [2:0]  forced;
    } tick_item_t;

    typedef struct packed {
        logic [2:0]  level;
        logic        changed;
        logic        critical;
        logic [8:0]  health;
        logic        stable;
        logic [15:0] avg;
        logic [7:0]  bad;
        logic [8:0]  good;
    } governor_result_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 s_tuser = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [2:0]           cfg_index = '0;
    logic [23:0]          cfg_data = '0;

    // register copies, reset values
    logic        cfg_auto   = 1'b1;
    logic [15:0] cfg_target = 16'd16667;
    logic [9:0]  cfg_sens   = 10'd256;
    logic [9:0]  cfg_crit   = 10'd384;
    logic [9:0]  cfg_bad    = 10'd282;
    logic [9:0]  cfg_good   = 10'd230;
    logic [7:0]  cfg_limit  = 8'd5;
    logic [23:0] cfg_settle = 24'd1000000;

    // governor state
    logic [15:0]     win_ring [WINDOW_DEPTH];
    longint unsigned win_sum = 0;
    int              win_count = 0;
    int              win_head = 0;
    logic [2:0]      level_q = LEVEL_MAX;
    int              bad_q = 0;
    int              good_q = 0;
    longint unsigned settle_q = 0;

    tick_item_t       pending_items[$];
    governor_result_t results_due[$];
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    int  dt_cap = 65535;
    int  accepted_items = 0;
    int  mismatches = 0;
    bit  took_item = 1'b0;
    bit  drain_hold = 1'b0;

    frame_time_quality_governor u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always #4 aclk = ~aclk;

    function automatic longint unsigned window_average();
        return (win_count == 0) ? 0 : win_sum / win_count;
    endfunction

    function automatic void take_level(input logic [2:0] lvl);
        level_q  = lvl;
        settle_q = 0;
        bad_q    = 0;
        good_q   = 0;
    endfunction

    function automatic governor_result_t advance_governor(input tick_item_t it);
        governor_result_t res;
        logic [2:0]       old_level;
        logic [2:0]       goal_level;
        bit               critical;
        longint unsigned  tgt;
        longint unsigned  avg;
        longint unsigned  scaled;
        longint unsigned  r;
        longint unsigned  health;
        old_level = level_q;
        critical  = 1'b0;
        tgt = (cfg_target == 16'd0) ? 64'd1 : 64'(cfg_target);
        if (it.action == ACTION_FORCE) begin
            if (it.forced <= LEVEL_MAX)
                take_level(it.forced);
        end else if (cfg_auto) begin
            goal_level = level_q;
            if (win_count < WINDOW_DEPTH)
                win_count++;
            else
                win_sum -= win_ring[win_head];
            win_sum += it.frame_us;
            win_ring[win_head] = it.frame_us;
            win_head = (win_head + 1) % WINDOW_DEPTH;
            avg = window_average();
            scaled = avg * cfg_sens;
            if (scaled >= cfg_crit * tgt) begin
                critical   = 1'b1;
                goal_level = LEVEL_MIN;
            end else if (scaled >= cfg_bad * tgt) begin
                if (bad_q < 255) bad_q++;
                good_q = 0;
                if (bad_q >= cfg_limit && settle_q >= cfg_settle)
                    goal_level = (level_q > LEVEL_MIN) ? level_q - 3'd1 : LEVEL_MIN;
            end else if (scaled <= cfg_good * tgt) begin
                if (good_q < 511) good_q++;
                bad_q = 0;
                if (good_q >= 2 * cfg_limit && settle_q >= 2 * longint'(cfg_settle))
                    goal_level = (level_q < LEVEL_MAX) ? level_q + 3'd1 : LEVEL_MAX;
            end else begin
                bad_q  = 0;
                good_q = 0;
            end
            if (goal_level != level_q)
                take_level(goal_level);
            settle_q = settle_q + it.delta_us;
            if (settle_q > 64'hFFFF_FFFF)
                settle_q = 64'hFFFF_FFFF;
        end
        avg    = window_average();
        r      = (avg << 8) / tgt;
        health = (r >= 512) ? 0 : 512 - r;
        if (health > 256)
            health = 256;
        res.level    = level_q;
        res.changed  = (level_q != old_level);
        res.critical = critical;
        res.health   = health[8:0];
        res.stable   = (bad_q == 0 && good_q < cfg_limit);
        res.avg      = avg[15:0];
        res.bad      = bad_q[7:0];
        res.good     = good_q[8:0];
        return res;
    endfunction

    function automatic string describe(input governor_result_t r);
        return $sformatf("lvl=%0d chg=%0b crit=%0b health=%0d stable=%0b avg=%0d bad=%0d good=%0d",
                         r.level, r.changed, r.critical, r.health, r.stable, r.avg, r.bad,
                         r.good);
    endfunction

    function automatic void queue_tick(input logic [15:0] ft, input logic [15:0] dt,
                                       input logic [2:0] fl);
        tick_item_t it;
        it.action   = ACTION_TICK;
        it.frame_us = ft;
        it.delta_us = dt;
        it.forced   = fl;
        pending_items.push_back(it);
    endfunction

    function automatic void queue_force(input logic [2:0] lvl);
        tick_item_t it;
        it.action   = ACTION_FORCE;
        it.frame_us = 16'($urandom_range(65535, 0));
        it.delta_us = 16'($urandom_range(65535, 0));
        it.forced   = lvl;
        pending_items.push_back(it);
    endfunction

    // frame time whose scaled ratio lands near q (Q8)
    function automatic logic [15:0] ratio_to_frame(input int q);
        longint unsigned tgt;
        longint unsigned f;
        tgt = (cfg_target == 16'd0) ? 64'd1 : 64'(cfg_target);
        f = (longint'(q) * tgt) / ((cfg_sens == 10'd0) ? 1 : cfg_sens);
        return (f > 65535) ? 16'hFFFF : f[15:0];
    endfunction

    // runs of good, bad, critical and neutral frames, forces and noise
    function automatic void queue_mix(input int n);
        int added;
        int kind;
        int len;
        int lo;
        int hi;
        added = 0;
        while (added < n) begin
            kind = $urandom_range(19, 0);
            len  = 1;
            if (kind <= 15) begin
                if (kind <= 6) begin
                    lo = 0;
                    hi = int'(cfg_good);
                    len = $urandom_range(70, 4);
                end else if (kind <= 11) begin
                    lo = int'(cfg_bad);
                    hi = (cfg_crit > cfg_bad) ? int'(cfg_crit) - 1 : int'(cfg_bad);
                    len = $urandom_range(30, 3);
                end else if (kind <= 13) begin
                    lo = int'(cfg_crit);
                    hi = 1023;
                    len = $urandom_range(4, 1);
                end else begin
                    lo = int'(cfg_good) + 1;
                    hi = (int'(cfg_bad) > int'(cfg_good) + 1) ? int'(cfg_bad) - 1 : lo;
                    len = $urandom_range(10, 1);
                end
                for (int i = 0; i < len; i++)
                    queue_tick(ratio_to_frame($urandom_range(hi, lo)),
                               16'($urandom_range(dt_cap, 0)), 3'($urandom_range(7, 0)));
            end else if (kind <= 17) begin
                queue_force(3'($urandom_range(7, 0)));
            end else begin
                len = $urandom_range(5, 1);
                for (int i = 0; i < len; i++)
                    queue_tick(16'($urandom_range(65535, 0)), 16'($urandom_range(65535, 0)),
                               3'($urandom_range(7, 0)));
            end
            added += len;
        end
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [23:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            CFG_AUTO_ENABLE: cfg_auto   = val[0];
            CFG_TARGET:      cfg_target = val[15:0];
            CFG_SENSITIVITY: cfg_sens   = val[9:0];
            CFG_CRITICAL:    cfg_crit   = val[9:0];
            CFG_BAD:         cfg_bad    = val[9:0];
            CFG_GOOD:        cfg_good   = val[9:0];
            CFG_RUN_LIMIT:   cfg_limit  = val[7:0];
            CFG_SETTLE:      cfg_settle = val;
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic setup(input logic en, input logic [15:0] tgt, input logic [9:0] sens,
                         input logic [9:0] crit, input logic [9:0] bad, input logic [9:0] good,
                         input logic [7:0] lim, input logic [23:0] settle);
        write_reg(CFG_AUTO_ENABLE, 24'(en));
        write_reg(CFG_TARGET, 24'(tgt));
        write_reg(CFG_SENSITIVITY, 24'(sens));
        write_reg(CFG_CRITICAL, 24'(crit));
        write_reg(CFG_BAD, 24'(bad));
        write_reg(CFG_GOOD, 24'(good));
        write_reg(CFG_RUN_LIMIT, 24'(lim));
        write_reg(CFG_SETTLE, settle);
    endtask

    task automatic wait_idle();
        while (pending_items.size() != 0 || s_tvalid || results_due.size() != 0)
            @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic run_phase(input int n, input int sp, input int rp);
        send_idle_pct  = sp;
        recv_stall_pct = rp;
        queue_mix(n);
        wait_idle();
    endtask

    // drive inputs on the falling edge
    always @(negedge aclk) begin
        tick_item_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            m_tready <= 1'b0;
        end else begin
            if (drain_hold && results_due.size() == 0)
                drain_hold = 1'b0;
            if (!s_tvalid || took_item) begin
                took_item = 1'b0;
                if (pending_items.size() > 0 && !drain_hold &&
                    $urandom_range(99, 0) >= send_idle_pct) begin
                    nxt = pending_items.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {5'b0, nxt.forced, nxt.delta_us, nxt.frame_us};
                    s_tuser  <= nxt.action;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
        end
    end

    // check results and predict on the rising edge
    always @(posedge aclk) begin
        governor_result_t got;
        governor_result_t due;
        tick_item_t       seen;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got.level    = m_tdata[2:0];
                got.changed  = m_tdata[3];
                got.critical = m_tdata[4];
                got.health   = m_tdata[13:5];
                got.stable   = m_tdata[14];
                got.avg      = m_tdata[30:15];
                got.bad      = m_tdata[38:31];
                got.good     = m_tdata[47:39];
                if (results_due.size() == 0) begin
                    $display("%0t ERROR result with none due: actual %s", $time, describe(got));
                    mismatches++;
                end else begin
                    due = results_due.pop_front();
                    if (got !== due) begin
                        $display("%0t ERROR result mismatch: expected %s actual %s",
                                 $time, describe(due), describe(got));
                        mismatches++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                seen.action   = s_tuser;
                seen.frame_us = s_tdata[15:0];
                seen.delta_us = s_tdata[31:16];
                seen.forced   = s_tdata[34:32];
                results_due.push_back(advance_governor(seen));
                took_item = 1'b1;
                accepted_items++;
                if (accepted_items % 97 == 0)
                    drain_hold = 1'b1;
            end
        end
    end

    initial begin
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // field extremes, every force level, out-of-range forces
        queue_tick(16'd16667, 16'd0, 3'd0);
        queue_tick(16'hFFFF, 16'hFFFF, 3'd7);
        queue_tick(16'h0000, 16'hFFFF, 3'd0);
        for (int lv = 0; lv < 8; lv++)
            queue_force(3'(lv));
        queue_force(LEVEL_MAX);
        wait_idle();

        // ticks with auto disabled
        write_reg(CFG_AUTO_ENABLE, 24'd0);
        queue_tick(16'hFFFF, 16'hFFFF, 3'd0);
        queue_tick(16'd0, 16'd100, 3'd0);
        queue_force(3'd2);
        wait_idle();

        // zero target, then steps past both ends
        setup(1'b1, 16'd0, 10'd1, 10'd1023, 10'd600, 10'd300, 8'd1, 24'd0);
        queue_tick(16'd0, 16'd10, 3'd0);
        queue_tick(16'd400, 16'd10, 3'd0);
        queue_force(LEVEL_MIN);
        queue_tick(16'd2000, 16'd10, 3'd0);
        queue_tick(16'd2000, 16'd10, 3'd0);
        queue_force(LEVEL_MAX);
        for (int i = 0; i < 4; i++)
            queue_tick(16'd0, 16'd10, 3'd0);
        wait_idle();

        setup(1'b1, 16'd16667, 10'd256, 10'd384, 10'd282, 10'd230, 8'd5, 24'd1000000);
        run_phase(60, 0, 0);
        setup(1'b1, 16'd1000, 10'd256, 10'd384, 10'd282, 10'd230, 8'd2, 24'd3000);
        dt_cap = 2000;
        run_phase(55, 64, 0);
        setup(1'b1, 16'hFFFF, 10'd1023, 10'd1023, 10'd700, 10'd300, 8'd1, 24'd0);
        dt_cap = 65535;
        run_phase(50, 0, 64);
        setup(1'b1, 16'd20000, 10'd128, 10'd600, 10'd400, 10'd200, 8'd3, 24'd50000);
        run_phase(50, 7, 7);
        setup(1'b1, 16'($urandom_range(40000, 500)), 10'($urandom_range(1023, 64)),
              10'($urandom_range(1023, 700)), 10'($urandom_range(650, 300)),
              10'($urandom_range(280, 0)), 8'($urandom_range(8, 1)),
              24'($urandom_range(200000, 0)));
        run_phase(50, 64, 64);
        setup(1'b1, 16'($urandom_range(65535, 1)), 10'($urandom_range(1023, 1)),
              10'($urandom_range(1023, 0)), 10'($urandom_range(1023, 0)),
              10'($urandom_range(1023, 0)), 8'($urandom_range(255, 1)),
              24'($urandom_range(16777215, 0)));
        run_phase(30, 0, 0);

        // auto disabled with forces mixed in
        write_reg(CFG_AUTO_ENABLE, 24'd0);
        run_phase(20, 7, 7);

        // every frame good, then every frame bad: counters saturate
        setup(1'b1, 16'hFFFF, 10'd1, 10'd1023, 10'd1023, 10'd1023, 8'd255, 24'hFFFFFF);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        for (int i = 0; i < 520; i++)
            queue_tick(16'($urandom_range(65535, 0)), 16'($urandom_range(1000, 0)), 3'd0);
        wait_idle();
        write_reg(CFG_BAD, 24'd0);
        for (int i = 0; i < 262; i++)
            queue_tick(16'($urandom_range(65535, 0)), 16'($urandom_range(1000, 0)), 3'd0);
        wait_idle();

        // every frame critical
        setup(1'b1, 16'd1, 10'd1, 10'd0, 10'd0, 10'd0, 8'd1, 24'd0);
        run_phase(12, 64, 64);

        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial begin
        #5000000;
        $display("FAIL");
        $finish;
    end

endmodule

// ===== frame_time_quality_governor.f =====
+incdir+rtl
rtl/ftqg_pkg.sv
rtl/ftqg_div.sv
rtl/frame_time_quality_governor.sv
rtl/ftqg_chk.sv
test/frame_time_quality_governor_tb.sv
